// ----- rtl/sdc_pkg.sv -----
// Package for the scaled decimal compare unit.
// Holds the input and result word types and the predicate codes; no dependencies.
`default_nettype none
package sdc_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned ScaleW  = 5;
  localparam int unsigned ActionW = 3;

  typedef enum logic [ActionW-1:0] {
    ActEq = 3'd0,
    ActNe = 3'd1,
    ActGt = 3'd2,
    ActLt = 3'd3,
    ActGe = 3'd4,
    ActLe = 3'd5
  } act_e;

  typedef struct packed {
    logic        [ActionW-1:0] action;
    logic signed [ValueW-1:0]  left_value;
    logic        [ScaleW-1:0]  left_scale;
    logic signed [ValueW-1:0]  right_value;
    logic        [ScaleW-1:0]  right_scale;
  } in_word_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic              holds;
  } out_word_t;

endpackage
`default_nettype wire

// ----- rtl/scaled_decimal_compare_unit.sv -----
// Top level of the scaled decimal compare unit.
// Depends on sdc_pkg and sdc_cell.
//
// The unit takes one word per cycle while in_stall_o is low. Each word passes through
// a chain of MAX_SCALE cells, each of which multiplies the
// operand with fewer fractional digits by ten until both share a scale, followed by
// one output register holding the signed compare and the predicate.
`default_nettype none
module scaled_decimal_compare_unit #(
  parameter int unsigned MAX_SCALE = 18
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sdc_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sdc_pkg::out_word_t      out_word_o
);
  import sdc_pkg::*;

  localparam int unsigned W  = ValueW + 4 * MAX_SCALE;
  localparam int unsigned DW = $clog2(MAX_SCALE + 1);

  logic                     st_valid      [0:MAX_SCALE];
  logic                     st_ready      [0:MAX_SCALE];
  logic [ActionW-1:0]       st_action     [0:MAX_SCALE];
  logic                     st_left_small [0:MAX_SCALE];
  logic [DW-1:0]            st_diff       [0:MAX_SCALE];
  logic signed [W-1:0]      st_small      [0:MAX_SCALE];
  logic signed [ValueW-1:0] st_big        [0:MAX_SCALE];

  logic [ScaleW-1:0] ls_c, rs_c;
  logic              left_small;

  always_comb begin
    ls_c = (in_word_i.left_scale > ScaleW'(MAX_SCALE)) ? ScaleW'(MAX_SCALE)
                                                       : in_word_i.left_scale;
    rs_c = (in_word_i.right_scale > ScaleW'(MAX_SCALE)) ? ScaleW'(MAX_SCALE)
                                                        : in_word_i.right_scale;
    left_small = ls_c < rs_c;
  end

  assign st_valid[0]      = in_valid_i;
  assign in_stall_o       = !st_ready[0];
  assign st_action[0]     = in_word_i.action;
  assign st_left_small[0] = left_small;
  assign st_diff[0]       = left_small ? DW'(rs_c - ls_c) : DW'(ls_c - rs_c);
  assign st_small[0]      = left_small ? W'(in_word_i.left_value)
                                       : W'(in_word_i.right_value);
  assign st_big[0]        = left_small ? in_word_i.right_value : in_word_i.left_value;

  for (genvar k = 0; k < MAX_SCALE; k++) begin : g_cell
    sdc_cell #(
      .W (W),
      .DW(DW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .valid_i     (st_valid[k]),
      .ready_o     (st_ready[k]),
      .action_i    (st_action[k]),
      .left_small_i(st_left_small[k]),
      .diff_i      (st_diff[k]),
      .small_i     (st_small[k]),
      .big_i       (st_big[k]),
      .valid_o     (st_valid[k+1]),
      .ready_i     (st_ready[k+1]),
      .action_o    (st_action[k+1]),
      .left_small_o(st_left_small[k+1]),
      .diff_o      (st_diff[k+1]),
      .small_o     (st_small[k+1]),
      .big_o       (st_big[k+1])
    );
  end

  logic                out_valid_q;
  out_word_t           out_word_q, out_word_d;
  logic signed [W-1:0] lhs, rhs;
  logic                gt, lt;

  assign st_ready[MAX_SCALE] = !out_valid_q || !out_stall_i;

  always_comb begin
    lhs = st_left_small[MAX_SCALE] ? st_small[MAX_SCALE] : W'(st_big[MAX_SCALE]);
    rhs = st_left_small[MAX_SCALE] ? W'(st_big[MAX_SCALE]) : st_small[MAX_SCALE];
    gt  = lhs > rhs;
    lt  = lhs < rhs;
    out_word_d.order = gt ? 2'sb01 : (lt ? 2'sb11 : 2'sb00);
    case (act_e'(st_action[MAX_SCALE]))
      ActEq:   out_word_d.holds = !gt && !lt;
      ActNe:   out_word_d.holds = gt || lt;
      ActGt:   out_word_d.holds = gt;
      ActLt:   out_word_d.holds = lt;
      ActGe:   out_word_d.holds = !lt;
      ActLe:   out_word_d.holds = !gt;
      default: out_word_d.holds = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_ready[MAX_SCALE]) begin
      out_valid_q <= st_valid[MAX_SCALE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready[MAX_SCALE] && st_valid[MAX_SCALE]) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.order != 2'sb10)
    else $error("Result order carries an invalid code.");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid[MAX_SCALE] |-> st_diff[MAX_SCALE] == '0)
    else $error("Word left the chain with its scales not aligned.");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !g_cell[0].u_cell.valid_o |-> !in_stall_o)
    else $error("Input stalled while the first cell is empty.");

endmodule
`default_nettype wire

// ----- rtl/sdc_cell.sv -----
// One cell of the alignment chain: scales the operand with fewer fractional digits by ten if the scales still differ.
// Depends on sdc_pkg.
`default_nettype none
module sdc_cell #(
  parameter int unsigned W  = 136,
  parameter int unsigned DW = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  output logic                                ready_o,
  input  wire logic [sdc_pkg::ActionW-1:0]    action_i,
  input  wire logic                           left_small_i,
  input  wire logic [DW-1:0]                  diff_i,
  input  wire logic signed [W-1:0]            small_i,
  input  wire logic signed [sdc_pkg::ValueW-1:0] big_i,
  output logic                                valid_o,
  input  wire logic                           ready_i,
  output logic [sdc_pkg::ActionW-1:0]         action_o,
  output logic                                left_small_o,
  output logic [DW-1:0]                       diff_o,
  output logic signed [W-1:0]                 small_o,
  output logic signed [sdc_pkg::ValueW-1:0]   big_o
);
  import sdc_pkg::*;

  logic                     valid_q;
  logic [ActionW-1:0]       action_q;
  logic                     left_small_q;
  logic [DW-1:0]            diff_q, diff_d;
  logic signed [W-1:0]      small_q, small_d;
  logic signed [ValueW-1:0] big_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (diff_i != '0) begin
      small_d = (small_i <<< 3) + (small_i <<< 1);
      diff_d  = diff_i - DW'(1);
    end else begin
      small_d = small_i;
      diff_d  = diff_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      action_q     <= action_i;
      left_small_q <= left_small_i;
      diff_q       <= diff_d;
      small_q      <= small_d;
      big_q        <= big_i;
    end
  end

  assign valid_o      = valid_q;
  assign action_o     = action_q;
  assign left_small_o = left_small_q;
  assign diff_o       = diff_q;
  assign small_o      = small_q;
  assign big_o        = big_q;

endmodule
`default_nettype wire
